// File: rtl/cwbm_pkg.sv
package cwbm_pkg;
    localparam int MAX_ITEMS = 1048576;
    localparam int POS_W     = 21;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int ID_W      = 31;
    localparam int P_W       = 17;
    localparam int W_W       = 16;
    localparam int SUM_W     = 36;
    localparam int PROD_W    = P_W + SUM_W;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam logic [P_W-1:0] ONE_Q16 = P_W'(65536);

    // one closed cluster handed from front to back
    typedef struct packed {
        logic [P_W-1:0]   best_p;
        logic [W_W-1:0]   best_w;
        logic [SUM_W-1:0] total;
        logic [POS_W-1:0] pos;
        logic             last;
    } cwbm_job_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_DIV,
        BK_OUT
    } cwbm_bk_state_t;
endpackage

// File: rtl/cluster_weighted_bonferroni_min.sv
// channel | ports                                           | direction
// s_      | s_cluster_id s_p_value s_test_weight s_end_of_data | in, valid/ready
// m_      | m_adjusted_p m_best_position m_last_of_run      | out, valid/ready
// The front takes one test per cycle while the queue has room and no flush is held.
// Each closed cluster passes the back through a 17x36 multiply and a 53-step
// restoring divide by the best weight, one bit per cycle, then waits for m_ready.
// Synchronous active-low reset empties the queue and closes any open cluster.
// A stalled m_ready fills the four-entry queue, then holds s_ready low.
module cluster_weighted_bonferroni_min (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [cwbm_pkg::ID_W-1:0]   s_cluster_id,
    input  logic [cwbm_pkg::P_W-1:0]    s_p_value,
    input  logic [cwbm_pkg::W_W-1:0]    s_test_weight,
    input  logic                        s_end_of_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [cwbm_pkg::P_W-1:0]    m_adjusted_p,
    output logic [cwbm_pkg::POS_W-1:0]  m_best_position,
    output logic                        m_last_of_run
);
    import cwbm_pkg::*;

    logic      f_valid, f_ready, b_valid, b_ready;
    cwbm_job_t f_job, b_job;

    cwbm_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_cluster_id(s_cluster_id), .s_p_value(s_p_value),
        .s_test_weight(s_test_weight), .s_end_of_data(s_end_of_data),
        .job_valid(f_valid), .job(f_job), .job_ready(f_ready)
    );

    cwbm_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(f_valid), .wr_data(f_job), .wr_ready(f_ready),
        .rd_valid(b_valid), .rd_data(b_job), .rd_ready(b_ready)
    );

    cwbm_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .job_valid(b_valid), .job(b_job), .job_ready(b_ready),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_adjusted_p(m_adjusted_p), .m_best_position(m_best_position),
        .m_last_of_run(m_last_of_run)
    );
endmodule

// File: rtl/cwbm_front.sv
module cwbm_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [cwbm_pkg::ID_W-1:0]   s_cluster_id,
    input  logic [cwbm_pkg::P_W-1:0]    s_p_value,
    input  logic [cwbm_pkg::W_W-1:0]    s_test_weight,
    input  logic                        s_end_of_data,
    output logic                        job_valid,
    output cwbm_pkg::cwbm_job_t         job,
    input  logic                        job_ready
);
    import cwbm_pkg::*;

    // a pending second job (eod flush after id change) is held here
    logic                 hold_valid_reg, hold_valid_next;
    cwbm_job_t            hold_reg, hold_next;
    logic                 open_reg, open_next;
    logic [ID_W-1:0]      id_reg, id_next;
    logic [P_W-1:0]       bp_reg, bp_next;
    logic [W_W-1:0]       bw_reg, bw_next;
    logic [POS_W-1:0]     bi_reg, bi_next;
    logic [SUM_W-1:0]     tot_reg, tot_next;
    logic [CNT_W-1:0]     seen_reg, seen_next;

    logic [W_W-1:0]       w;
    logic [CNT_W-1:0]     seen_inc;
    logic                 change;
    logic [P_W+W_W-1:0]   lhs, rhs;
    logic [SUM_W:0]       sum;
    cwbm_job_t            old_job, new_job;
    logic                 acc;

    assign s_ready = !hold_valid_reg && job_ready;
    assign acc     = s_valid && s_ready;

    always_comb begin
        w        = (s_test_weight == '0) ? W_W'(1) : s_test_weight;
        seen_inc = (seen_reg < CNT_W'(MAX_ITEMS)) ? seen_reg + CNT_W'(1) : seen_reg;
        change   = open_reg && (s_cluster_id != id_reg);
        lhs      = s_p_value * bw_reg;
        rhs      = bp_reg * w;
        sum      = {1'b0, tot_reg} + {{(SUM_W+1-W_W){1'b0}}, w};

        open_next = open_reg;
        id_next   = id_reg;
        bp_next   = bp_reg;
        bw_next   = bw_reg;
        bi_next   = bi_reg;
        tot_next  = tot_reg;
        seen_next = seen_reg;
        hold_valid_next = hold_valid_reg;
        hold_next = hold_reg;

        old_job = '{best_p: bp_reg, best_w: bw_reg, total: tot_reg,
                    pos: bi_reg, last: !s_end_of_data};

        // advance the running minimum only on an accepted transaction
        if (acc) begin
            if (!open_reg || change) begin
                id_next  = s_cluster_id;
                bp_next  = s_p_value;
                bw_next  = w;
                bi_next  = POS_W'(seen_inc);
                tot_next = {{(SUM_W-W_W){1'b0}}, w};
            end else begin
                if (lhs < rhs) begin
                    bp_next = s_p_value;
                    bw_next = w;
                    bi_next = POS_W'(seen_inc);
                end
                tot_next = sum[SUM_W] ? {SUM_W{1'b1}} : sum[SUM_W-1:0];
            end
        end
        new_job = '{best_p: bp_next, best_w: bw_next, total: tot_next,
                    pos: bi_next, last: 1'b1};

        job_valid = hold_valid_reg;
        job       = hold_reg;
        if (acc) begin
            seen_next = seen_inc;
            open_next = 1'b1;
            if (change) begin
                job_valid = 1'b1;
                job       = old_job;
                if (s_end_of_data) begin
                    hold_valid_next = 1'b1;
                    hold_next       = new_job;
                end
            end else if (s_end_of_data) begin
                job_valid = 1'b1;
                job       = new_job;
            end
            if (s_end_of_data) begin
                open_next = 1'b0;
                seen_next = '0;
            end
        end else if (hold_valid_reg && job_ready) begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            open_reg       <= 1'b0;
            id_reg         <= '0;
            bp_reg         <= '0;
            bw_reg         <= W_W'(1);
            bi_reg         <= '0;
            tot_reg        <= '0;
            seen_reg       <= '0;
        end else begin
            hold_valid_reg <= hold_valid_next;
            open_reg       <= open_next;
            id_reg         <= id_next;
            bp_reg         <= bp_next;
            bw_reg         <= bw_next;
            bi_reg         <= bi_next;
            tot_reg        <= tot_next;
            seen_reg       <= seen_next;
        end
        hold_reg <= hold_next;
    end
endmodule

// File: rtl/cwbm_queue.sv
module cwbm_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_valid,
    input  cwbm_pkg::cwbm_job_t  wr_data,
    output logic                 wr_ready,
    output logic                 rd_valid,
    output cwbm_pkg::cwbm_job_t  rd_data,
    input  logic                 rd_ready
);
    import cwbm_pkg::*;

    cwbm_job_t         mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wp_reg, rp_reg;
    logic [QPTR_W:0]   cnt_reg;
    logic              wr, rd;

    assign wr_ready = cnt_reg != (QPTR_W+1)'(QDEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_data  = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= wp_reg + QPTR_W'(1);
            if (rd) rp_reg <= rp_reg + QPTR_W'(1);
            cnt_reg <= cnt_reg + (QPTR_W+1)'(wr) - (QPTR_W+1)'(rd);
        end
        if (wr) mem_reg[wp_reg] <= wr_data;
    end
endmodule

// File: rtl/cwbm_back.sv
module cwbm_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        job_valid,
    input  cwbm_pkg::cwbm_job_t         job,
    output logic                        job_ready,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [cwbm_pkg::P_W-1:0]    m_adjusted_p,
    output logic [cwbm_pkg::POS_W-1:0]  m_best_position,
    output logic                        m_last_of_run
);
    import cwbm_pkg::*;

    localparam int STEP_W = $clog2(PROD_W + 1);

    cwbm_bk_state_t     st_reg, st_next;
    cwbm_job_t          job_reg;
    logic [PROD_W-1:0]  num_reg;
    logic [W_W:0]       rem_reg;
    logic [PROD_W-1:0]  quo_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [W_W:0]       trial;
    logic [W_W:0]       diff;

    // restoring division, one quotient bit per cycle
    always_comb begin
        trial = {rem_reg[W_W-1:0], num_reg[PROD_W-1]};
        diff  = trial - {1'b0, job_reg.best_w};
    end

    always_comb begin
        st_next   = st_reg;
        job_ready = 1'b0;
        m_valid   = 1'b0;
        unique case (st_reg)
            BK_IDLE: begin
                job_ready = 1'b1;
                if (job_valid) st_next = BK_MUL;
            end
            BK_MUL: st_next = BK_DIV;
            BK_DIV: if (step_reg == STEP_W'(PROD_W - 1)) st_next = BK_OUT;
            BK_OUT: begin
                m_valid = 1'b1;
                if (m_ready) st_next = BK_IDLE;
            end
            default: st_next = BK_IDLE;
        endcase
    end

    assign m_adjusted_p    = (quo_reg > PROD_W'(ONE_Q16)) ? ONE_Q16 : quo_reg[P_W-1:0];
    assign m_best_position = job_reg.pos;
    assign m_last_of_run   = job_reg.last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= BK_IDLE;
        end else begin
            st_reg <= st_next;
        end
        unique case (st_reg)
            BK_IDLE: begin
                if (job_valid) job_reg <= job;
            end
            BK_MUL: begin
                num_reg  <= job_reg.best_p * job_reg.total;
                rem_reg  <= '0;
                quo_reg  <= '0;
                step_reg <= '0;
            end
            BK_DIV: begin
                num_reg  <= {num_reg[PROD_W-2:0], 1'b0};
                step_reg <= step_reg + STEP_W'(1);
                if (!diff[W_W]) begin
                    rem_reg <= diff;
                    quo_reg <= {quo_reg[PROD_W-2:0], 1'b1};
                end else begin
                    rem_reg <= trial;
                    quo_reg <= {quo_reg[PROD_W-2:0], 1'b0};
                end
            end
            default: ;
        endcase
    end
endmodule

// File: dv/cluster_weighted_bonferroni_min_tb.sv
`timescale 1ns / 1ps

module cluster_weighted_bonferroni_min_tb;
    import cwbm_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_HOLDOFF  = 80;
    localparam int TAIL_ITEMS     = 100;

    typedef struct {
        logic [ID_W-1:0] id;
        logic [P_W-1:0]  p;
        logic [W_W-1:0]  w;
        logic            eod;
        bit              drain_first;
    } test_item_t;

    typedef struct {
        logic [P_W-1:0]   adj;
        logic [POS_W-1:0] pos;
        logic             last;
    } cluster_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [ID_W-1:0] s_cluster_id = '0;
    logic [P_W-1:0]  s_p_value = '0;
    logic [W_W-1:0]  s_test_weight = 16'd1;
    logic            s_end_of_data = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [P_W-1:0]   m_adjusted_p;
    logic [POS_W-1:0] m_best_position;
    logic             m_last_of_run;

    cluster_weighted_bonferroni_min DUT (.*);

    initial forever #5 aclk = ~aclk;

    test_item_t      pending_tests[$];
    cluster_result_t expected_clusters[$];
    int  errors = 0;
    int  tests_sent = 0;
    int  clusters_seen = 0;
    bit  tail = 1'b0;

    // Predicted cluster state.
    logic [ID_W-1:0]   cl_id = '0;
    bit                cl_open = 1'b0;
    logic [P_W-1:0]    cl_best_p = '0;
    logic [W_W-1:0]    cl_best_w = 16'd1;
    logic [POS_W-1:0]  cl_best_pos = '0;
    logic [SUM_W-1:0]  cl_weight_sum = '0;
    int unsigned       cl_position = 0;

    function automatic void close_cluster(logic last);
        cluster_result_t r;
        longint unsigned q;
        q = (64'(cl_best_p) * 64'(cl_weight_sum)) / 64'(cl_best_w);
        if (q > 64'd65536) q = 64'd65536;
        r.adj  = P_W'(q);
        r.pos  = cl_best_pos;
        r.last = last;
        expected_clusters.push_back(r);
    endfunction

    function automatic void predict_cluster(test_item_t t);
        logic [W_W-1:0] w;
        longint unsigned sum;
        w = (t.w == 0) ? 16'd1 : t.w;
        if (cl_position < MAX_ITEMS) cl_position++;
        if (cl_open && t.id != cl_id) begin
            close_cluster(!t.eod);
            cl_open = 1'b0;
        end
        if (!cl_open) begin
            cl_open       = 1'b1;
            cl_id         = t.id;
            cl_best_p     = t.p;
            cl_best_w     = w;
            cl_best_pos   = POS_W'(cl_position);
            cl_weight_sum = SUM_W'(w);
        end else begin
            if (64'(t.p) * 64'(cl_best_w) < 64'(cl_best_p) * 64'(w)) begin
                cl_best_p   = t.p;
                cl_best_w   = w;
                cl_best_pos = POS_W'(cl_position);
            end
            sum = 64'(cl_weight_sum) + 64'(w);
            if (sum > 64'hF_FFFF_FFFF) sum = 64'hF_FFFF_FFFF;
            cl_weight_sum = SUM_W'(sum);
        end
        if (t.eod) begin
            close_cluster(1'b1);
            cl_open = 1'b0;
            cl_position = 0;
        end
    endfunction

    function automatic void add_test(logic [ID_W-1:0] id, logic [P_W-1:0] p,
                                     logic [W_W-1:0] w, logic eod, bit drain_first = 0);
        test_item_t t;
        t.id = id; t.p = p; t.w = w; t.eod = eod; t.drain_first = drain_first;
        pending_tests.push_back(t);
    endfunction

    function automatic logic [P_W-1:0] rand_p();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return P_W'(65536);
            2: return P_W'($urandom_range(0, 255));
            default: return P_W'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [W_W-1:0] rand_w();
        case ($urandom_range(0, 9))
            0: return 16'd1;
            1: return 16'hFFFF;
            2: return W_W'($urandom_range(1, 16));
            default: return W_W'($urandom_range(1, 65535));
        endcase
    endfunction

    // Driver: present pending tests, idle in bursts, drain before flagged ones.
    int  gap_left = 0;
    int  holdoff = 0;
    bit  s_fire;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            s_fire = s_valid && s_ready;
            if (s_fire) begin
                predict_cluster('{s_cluster_id, s_p_value, s_test_weight, s_end_of_data, 0});
                tests_sent++;
            end
            tail = pending_tests.size() < TAIL_ITEMS;
            if (!s_valid || s_fire) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_tests.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (pending_tests[0].drain_first &&
                             (expected_clusters.size() != 0 || holdoff < DRAIN_HOLDOFF)) begin
                    if (expected_clusters.size() == 0) holdoff++;
                    else holdoff = 0;
                    s_valid <= 1'b0;
                end else if (!tail && $urandom_range(0, 5) == 0) begin
                    gap_left = $urandom_range(0, 8);
                    s_valid <= 1'b0;
                end else begin
                    test_item_t t;
                    t = pending_tests.pop_front();
                    holdoff = 0;
                    s_valid       <= 1'b1;
                    s_cluster_id  <= t.id;
                    s_p_value     <= t.p;
                    s_test_weight <= t.w;
                    s_end_of_data <= t.eod;
                end
            end
        end
    end

    // Monitor: random backpressure, compare each transaction with the oldest prediction.
    int stall_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                clusters_seen++;
                if (expected_clusters.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result adj=%0d pos=%0d last=%0d", $time,
                             m_adjusted_p, m_best_position, m_last_of_run);
                end else begin
                    cluster_result_t e;
                    e = expected_clusters.pop_front();
                    if (m_adjusted_p !== e.adj) begin
                        errors++;
                        $display("%0t: adjusted_p expected %0d actual %0d", $time,
                                 e.adj, m_adjusted_p);
                    end
                    if (m_best_position !== e.pos) begin
                        errors++;
                        $display("%0t: best_position expected %0d actual %0d", $time,
                                 e.pos, m_best_position);
                    end
                    if (m_last_of_run !== e.last) begin
                        errors++;
                        $display("%0t: last_of_run expected %0d actual %0d", $time,
                                 e.last, m_last_of_run);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!tail && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 8);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int n;
        int len;
        logic [ID_W-1:0] id;
        logic [ID_W-1:0] prev_id;
        // Directed: extremes, ties, zero weight, id change, flush and restart.
        add_test('0, '0, 16'd1, 0);
        add_test('0, P_W'(65536), 16'hFFFF, 0);
        add_test('0, P_W'(100), 16'd200, 0);
        add_test('0, P_W'(50), 16'd100, 1);            // same ratio as the test before; the zero p stays best
        add_test(31'h7FFF_FFFF, P_W'(65536), 16'hFFFF, 0);
        add_test(31'h7FFF_FFFF, P_W'(65536), 16'hFFFF, 0);
        add_test(31'h2AAA_AAAA, P_W'(1), 16'd0, 0);    // zero weight counts as one
        add_test(31'h5555_5555, P_W'(65535), 16'h8000, 1);   // id change together with flush
        add_test(31'd5, P_W'(20000), 16'd1, 1);               // single-test cluster, flushed
        add_test(31'd5, P_W'(30000), 16'd256, 0);             // same id after flush
        add_test(31'd6, P_W'(0), 16'd0, 0);
        add_test(31'd6, P_W'(65536), 16'd1, 0);
        add_test(31'd7, P_W'(12345), 16'h00FF, 0, 1);         // drain before this one
        add_test(31'd7, P_W'(54321), 16'hFF00, 1);
        // Random clusters: mostly well-formed runs, with occasional id reuse and early flush.
        prev_id = 31'd7;
        n = 0;
        while (n < 750) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
            if ($urandom_range(0, 9) == 0) id = ~prev_id;
            else id = ID_W'($urandom);
            if (id == prev_id && $urandom_range(0, 1)) id = id + ID_W'(1);
            for (int k = 0; k < len; k++) begin
                add_test(id, rand_p(), rand_w(),
                         (k == len - 1) && ($urandom_range(0, 5) == 0),
                         (n == 400 && k == 0));
                n++;
            end
            prev_id = id;
        end
        pending_tests[pending_tests.size() - 1].eod = 1'b1;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pending_tests.size() == 0);
        @(posedge aclk);
        while (s_valid || expected_clusters.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        $display("Sent %0d tests, checked %0d cluster results, with random stalls on both sides",
                 tests_sent, clusters_seen);
        $display("and a drain pause; %0d errors", errors);
        if (errors == 0 && expected_clusters.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
